>>> rtl/cndtrk_pkg.sv
// Package for the conditional nesting tracker: directive kinds, verdict and
// error codes, field widths and the result record shared by the execution unit,
// the top level and the testbench. No dependencies.
`timescale 1ns / 1ps

package cndtrk_pkg;

  localparam int MAX_DEPTH_DEF = 30;
  localparam int KIND_W        = 3;
  localparam int VERDICT_W     = 2;
  localparam int ERR_W         = 3;
  localparam int OPEN_W        = 5;
  localparam int SKIP_W        = 16;

  localparam logic [SKIP_W-1:0] SKIP_MAX = {SKIP_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_IF      = 3'd0,
    KIND_ELIF    = 3'd1,
    KIND_ELSE    = 3'd2,
    KIND_ENDIF   = 3'd3,
    KIND_EOF     = 3'd4,
    KIND_UNKNOWN = 3'd5
  } kind_t;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_PARSE   = 2'd0,
    VERDICT_SKIP    = 2'd1,
    VERDICT_INVALID = 2'd2
  } verdict_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 3'd0,
    ERR_ENDIF     = 3'd1,
    ERR_ELSE      = 3'd2,
    ERR_ELIF      = 3'd3,
    ERR_MALFORMED = 3'd4,
    ERR_DEEP      = 3'd5,
    ERR_OPEN      = 3'd6
  } err_t;

  typedef struct packed {
    verdict_t            verdict;
    err_t                error_code;
    logic [OPEN_W-1:0]   open_count;
  } result_t;

endpackage

>>> rtl/cndtrk_in_if.sv
// Directive input channel: valid/ready handshake with the directive payload.
// Depends on cndtrk_pkg for field widths.
`timescale 1ns / 1ps

interface cndtrk_in_if;
  logic                          valid;
  logic                          ready;
  logic [cndtrk_pkg::KIND_W-1:0] kind;
  logic                          expr_value;
  logic                          expr_ok;

  modport source (output valid, output kind, output expr_value, output expr_ok,
                  input ready);
  modport sink   (input valid, input kind, input expr_value, input expr_ok,
                  output ready);
endinterface

>>> rtl/cndtrk_out_if.sv
// Result channel: valid/ready handshake with verdict, error code and open count.
// Depends on cndtrk_pkg for field widths.
`timescale 1ns / 1ps

interface cndtrk_out_if;
  logic                             valid;
  logic                             ready;
  logic [cndtrk_pkg::VERDICT_W-1:0] verdict;
  logic [cndtrk_pkg::ERR_W-1:0]     error_code;
  logic [cndtrk_pkg::OPEN_W-1:0]    open_count;

  modport source (output valid, output verdict, output error_code, output open_count,
                  input ready);
  modport sink   (input valid, input verdict, input error_code, input open_count,
                  output ready);
endinterface

>>> rtl/cndtrk_stack_mem.sv
// Branch value stack storage: one-bit synchronous RAM, one write port and
// one registered read port with write-first forwarding. No dependencies.
`timescale 1ns / 1ps

module cndtrk_stack_mem #(
  parameter int DEPTH  = 30,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic              wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic              rd_data
);

  logic mem_r [DEPTH];
  logic rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // A write to the entry being read in the same cycle is passed straight on.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/cndtrk_exec.sv
// Directive execution: given one directive, the stack top value and the
// current counters, computes the next counters, the stack write and the result.
// Depends on cndtrk_pkg.
`timescale 1ns / 1ps

module cndtrk_exec #(
  parameter int MAX_DEPTH = 30,
  parameter int DEPTH_W   = 5,
  parameter int ADDR_W    = 5
) (
  input  logic [cndtrk_pkg::KIND_W-1:0] kind,
  input  logic                          expr_value,
  input  logic                          expr_ok,
  input  logic                          top_val,
  input  logic [DEPTH_W-1:0]            depth,
  input  logic [cndtrk_pkg::SKIP_W-1:0] skipped,
  input  logic                          skipping,
  output logic [DEPTH_W-1:0]            depth_nxt,
  output logic [cndtrk_pkg::SKIP_W-1:0] skipped_nxt,
  output logic                          skipping_nxt,
  output logic                          wr_en,
  output logic [ADDR_W-1:0]             wr_addr,
  output logic                          wr_data,
  output cndtrk_pkg::result_t           res
);
  import cndtrk_pkg::*;

  localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(MAX_DEPTH);

  logic [DEPTH_W-1:0]         depth_m1;
  logic [ADDR_W-1:0]          top_addr;
  logic [DEPTH_W+OPEN_W-1:0]  depth_ext;
  logic                       depth_zero;
  logic                       skip_busy;

  assign depth_m1   = depth - DEPTH_W'(1);
  assign top_addr   = depth_m1[ADDR_W-1:0];
  assign depth_ext  = {{OPEN_W{1'b0}}, depth};
  assign depth_zero = (depth == '0);
  assign skip_busy  = (skipped != '0);

  always_comb begin
    depth_nxt    = depth;
    skipped_nxt  = skipped;
    skipping_nxt = skipping;
    wr_en        = 1'b0;
    wr_addr      = top_addr;
    wr_data      = expr_value;
    res          = '{verdict: VERDICT_PARSE, error_code: ERR_NONE, open_count: '0};

    case (kind)
      KIND_IF: begin
        if (skipping) begin
          if (skipped != SKIP_MAX) begin
            skipped_nxt = skipped + SKIP_W'(1);
          end
          res.verdict = VERDICT_SKIP;
        end else if (!expr_ok) begin
          res.verdict    = VERDICT_INVALID;
          res.error_code = ERR_MALFORMED;
        end else if (depth == DEPTH_FULL) begin
          res.verdict    = VERDICT_INVALID;
          res.error_code = ERR_DEEP;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = depth[ADDR_W-1:0];
          depth_nxt    = depth + DEPTH_W'(1);
          skipping_nxt = !expr_value;
          res.verdict  = expr_value ? VERDICT_PARSE : VERDICT_SKIP;
        end
      end
      KIND_ELIF: begin
        if (depth_zero) begin
          res.verdict    = VERDICT_INVALID;
          res.error_code = ERR_ELIF;
        end else if (skip_busy) begin
          res.verdict = VERDICT_SKIP;
        end else if (!expr_ok) begin
          res.verdict    = VERDICT_INVALID;
          res.error_code = ERR_MALFORMED;
        end else if (top_val) begin
          skipping_nxt = 1'b1;
          res.verdict  = VERDICT_SKIP;
        end else begin
          wr_en        = 1'b1;
          skipping_nxt = !expr_value;
          res.verdict  = expr_value ? VERDICT_PARSE : VERDICT_SKIP;
        end
      end
      KIND_ELSE: begin
        if (depth_zero) begin
          res.verdict    = VERDICT_INVALID;
          res.error_code = ERR_ELSE;
        end else if (skip_busy) begin
          res.verdict = VERDICT_SKIP;
        end else if (top_val) begin
          skipping_nxt = 1'b1;
          res.verdict  = VERDICT_SKIP;
        end else begin
          wr_en        = 1'b1;
          wr_data      = 1'b1;
          skipping_nxt = 1'b0;
        end
      end
      KIND_ENDIF: begin
        if (skip_busy) begin
          skipped_nxt = skipped - SKIP_W'(1);
          res.verdict = VERDICT_SKIP;
        end else if (depth_zero) begin
          res.verdict    = VERDICT_INVALID;
          res.error_code = ERR_ENDIF;
        end else begin
          skipping_nxt = 1'b0;
          depth_nxt    = depth_m1;
        end
      end
      KIND_EOF: begin
        depth_nxt = '0;
        if (!depth_zero) begin
          res.verdict    = VERDICT_INVALID;
          res.error_code = ERR_OPEN;
          res.open_count = depth_ext[OPEN_W-1:0];
        end
      end
      default: begin
        res.verdict = VERDICT_INVALID;
      end
    endcase
  end

endmodule

>>> rtl/conditional_nesting_tracker_top.sv
// Conditional nesting tracker, top level. A transferring directive enters the
// execute stage as its stack top is read; it then executes into the output register.
// Throughput: one directive per cycle while results are not stalled, set by the
// single read-modify-write pass over the branch value RAM with forwarding.
// Reset (rst_n low, synchronous) clears depth, skip count, skip flag and all
// valids; the branch value RAM needs no clearing since each entry is pushed first.
`timescale 1ns / 1ps

module conditional_nesting_tracker_top #(
  parameter int MAX_DEPTH = cndtrk_pkg::MAX_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  cndtrk_in_if.sink    in_ch,
  cndtrk_out_if.source out_ch
);
  import cndtrk_pkg::*;

  // The depth counter must hold MAX_DEPTH itself; RAM addresses only reach
  // MAX_DEPTH-1.
  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int ADDR_W  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // Architectural state of the tracker.
  logic [DEPTH_W-1:0] depth_r;
  logic [SKIP_W-1:0]  skipped_r;
  logic               skipping_r;

  // Execute stage: the directive whose stack top read is under way.
  logic              s1_valid_r;
  logic [KIND_W-1:0] s1_kind_r;
  logic              s1_value_r;
  logic              s1_ok_r;

  // Output register, parting the execute stage from the result consumer.
  logic    out_valid_r;
  result_t out_res_r;

  logic               in_fire;
  logic               s1_fire;
  logic [DEPTH_W-1:0] depth_nxt;
  logic [SKIP_W-1:0]  skipped_nxt;
  logic               skipping_nxt;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic               wr_data;
  logic               top_val;
  result_t            exec_res;
  logic [DEPTH_W-1:0] rd_depth;
  logic [DEPTH_W-1:0] rd_depth_m1;
  logic [ADDR_W-1:0]  rd_addr;

  // The execute stage retires whenever the output register is free or being
  // drained; a new directive can enter in the same cycle.
  assign s1_fire     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // The incoming directive reads the stack top as it will be after the
  // directive that executes this cycle. A same-cycle write to that entry is
  // forwarded inside the RAM read port.
  assign rd_depth    = s1_fire ? depth_nxt : depth_r;
  assign rd_depth_m1 = rd_depth - DEPTH_W'(1);
  assign rd_addr     = rd_depth_m1[ADDR_W-1:0];

  cndtrk_stack_mem #(
    .DEPTH  (MAX_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_stack_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_fire),
    .rd_addr (rd_addr),
    .rd_data (top_val)
  );

  logic exec_wr_en;

  cndtrk_exec #(
    .MAX_DEPTH (MAX_DEPTH),
    .DEPTH_W   (DEPTH_W),
    .ADDR_W    (ADDR_W)
  ) u_exec (
    .kind         (s1_kind_r),
    .expr_value   (s1_value_r),
    .expr_ok      (s1_ok_r),
    .top_val      (top_val),
    .depth        (depth_r),
    .skipped      (skipped_r),
    .skipping     (skipping_r),
    .depth_nxt    (depth_nxt),
    .skipped_nxt  (skipped_nxt),
    .skipping_nxt (skipping_nxt),
    .wr_en        (exec_wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .res          (exec_res)
  );

  // Stack writes only take effect when the directive actually retires.
  assign wr_en = exec_wr_en && s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r    <= '0;
      skipped_r  <= '0;
      skipping_r <= 1'b0;
    end else if (s1_fire) begin
      depth_r    <= depth_nxt;
      skipped_r  <= skipped_nxt;
      skipping_r <= skipping_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r  <= in_ch.kind;
      s1_value_r <= in_ch.expr_value;
      s1_ok_r    <= in_ch.expr_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_res_r <= exec_res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.verdict    = out_res_r.verdict;
  assign out_ch.error_code = out_res_r.error_code;
  assign out_ch.open_count = out_res_r.open_count;

  // Skipped nested levels only exist while lines are being skipped.
  a_skip_implies_skipping: assert property (@(posedge clk) disable iff (!rst_n)
    (skipped_r != '0) |-> skipping_r)
    else $error("skip count nonzero while not skipping");

  // The stack never grows past its capacity.
  a_depth_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_W'(MAX_DEPTH))
    else $error("nesting depth beyond capacity");

  // A stalled result holds the execute stage and the tracker state.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ch.ready) |=>
      (s1_valid_r && $stable(depth_r) && $stable(skipped_r) && $stable(skipping_r)))
    else $error("state moved while result stalled");

  // End of file empties the stack.
  a_eof_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && (s1_kind_r == KIND_EOF)) |=> (depth_r == '0))
    else $error("stack not empty after end of file");

endmodule

>>> sim/tb_conditional_nesting_tracker_top.sv
// Self-checking testbench for conditional_nesting_tracker_top: directed and random
// directive streams over valid/ready channels, checked against an in-bench predictor.
// Depends on cndtrk_pkg, cndtrk_in_if, cndtrk_out_if and the top-level RTL.
`timescale 1ns / 1ps

module tb_conditional_nesting_tracker_top;
  import cndtrk_pkg::*;

  // The stack size matches the default of the block; the skip counter ceiling
  // comes from the package.
  localparam int unsigned DEPTH_LIMIT = MAX_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 6;

  // The kind field is three bits wide, so codes past the named unknown kind can
  // still arrive. The block must treat them as unknown directives.
  localparam logic [KIND_W-1:0] KIND_RSVD_6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD_7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Local copies of the driven channel signals. They start at known values and
  // are only changed by nonblocking assignments at the rising edge.
  logic              snd_valid = 1'b0;
  logic [KIND_W-1:0] snd_kind = KIND_UNKNOWN;
  logic              snd_value = 1'b0;
  logic              snd_ok = 1'b0;
  logic              rcv_ready = 1'b0;

  // Percentages for the idling of each side; changed between test phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // Predictor state: one taken flag per open evaluated conditional, the open
  // depth, the count of conditionals opened while skipping, and the skip flag.
  bit          branch_taken [DEPTH_LIMIT];
  int unsigned open_depth = 0;
  int unsigned nested_skips = 0;
  bit          skipping_now = 1'b0;

  // Verdicts predicted for accepted directives, oldest first.
  result_t pending_verdicts [$];
  result_t oldest_verdict;

  cndtrk_in_if  in_ch ();
  cndtrk_out_if out_ch ();

  assign in_ch.valid      = snd_valid;
  assign in_ch.kind       = snd_kind;
  assign in_ch.expr_value = snd_value;
  assign in_ch.expr_ok    = snd_ok;
  assign out_ch.ready     = rcv_ready;

  conditional_nesting_tracker_top #(
    .MAX_DEPTH(DEPTH_LIMIT)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Computes the verdict for one directive and advances the predictor state.
  // The order of the checks matters: a skipped level hides else and elif
  // before their expression is looked at, and a malformed if is rejected
  // before the stack is checked for room.
  function automatic result_t predict_directive(input logic [KIND_W-1:0] k,
                                                input logic v, input logic ok);
    result_t     r;
    int unsigned top;
    r.verdict    = VERDICT_INVALID;
    r.error_code = ERR_NONE;
    r.open_count = '0;
    top = (open_depth > 0) ? open_depth - 1 : 0;
    case (k)
      KIND_IF: begin
        if (skipping_now) begin
          // Nested opens inside skipped text are only counted; the count
          // sticks at its ceiling.
          if (nested_skips < SKIP_MAX) begin
            nested_skips++;
          end
          r.verdict = VERDICT_SKIP;
        end else if (!ok) begin
          r.error_code = ERR_MALFORMED;
        end else if (open_depth >= DEPTH_LIMIT) begin
          r.error_code = ERR_DEEP;
        end else begin
          branch_taken[open_depth] = v;
          open_depth++;
          skipping_now = !v;
          r.verdict = v ? VERDICT_PARSE : VERDICT_SKIP;
        end
      end
      KIND_ELIF: begin
        if (open_depth == 0) begin
          r.error_code = ERR_ELIF;
        end else if (nested_skips != 0) begin
          r.verdict = VERDICT_SKIP;
        end else if (!ok) begin
          r.error_code = ERR_MALFORMED;
        end else if (branch_taken[top]) begin
          skipping_now = 1'b1;
          r.verdict = VERDICT_SKIP;
        end else begin
          branch_taken[top] = v;
          skipping_now = !v;
          r.verdict = v ? VERDICT_PARSE : VERDICT_SKIP;
        end
      end
      KIND_ELSE: begin
        if (open_depth == 0) begin
          r.error_code = ERR_ELSE;
        end else if (nested_skips != 0) begin
          r.verdict = VERDICT_SKIP;
        end else if (branch_taken[top]) begin
          skipping_now = 1'b1;
          r.verdict = VERDICT_SKIP;
        end else begin
          branch_taken[top] = 1'b1;
          skipping_now = 1'b0;
          r.verdict = VERDICT_PARSE;
        end
      end
      KIND_ENDIF: begin
        if (nested_skips != 0) begin
          nested_skips--;
          r.verdict = VERDICT_SKIP;
        end else if (open_depth == 0) begin
          r.error_code = ERR_ENDIF;
        end else begin
          skipping_now = 1'b0;
          open_depth--;
          r.verdict = VERDICT_PARSE;
        end
      end
      KIND_EOF: begin
        // End of file empties the stack but leaves the skip state alone.
        if (open_depth != 0) begin
          r.error_code = ERR_OPEN;
          r.open_count = OPEN_W'(open_depth);
        end else begin
          r.verdict = VERDICT_PARSE;
        end
        open_depth = 0;
      end
      default: begin
        // Unknown directives are rejected without an error code.
      end
    endcase
    return r;
  endfunction

  // Offers one directive, idling first at the current sender rate, and waits
  // for its transfer. The prediction is made at the transfer edge so that the
  // queue follows the order in which the block accepted the directives.
  task automatic send_directive(input logic [KIND_W-1:0] k, input logic v,
                                input logic ok);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      snd_valid <= 1'b0;
      @(posedge clk);
    end
    snd_valid <= 1'b1;
    snd_kind  <= k;
    snd_value <= v;
    snd_ok    <= ok;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    pending_verdicts.push_back(predict_directive(k, v, ok));
  endtask

  // Holds the sender idle until every predicted verdict has been returned.
  task automatic wait_results_drained();
    snd_valid <= 1'b0;
    while (pending_verdicts.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Result checker. Each transfer on the result channel is matched against the
  // oldest prediction; the ready for the next edge is drawn here as well.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result transfer: verdict %0d error %0d open %0d",
                 $time, out_ch.verdict, out_ch.error_code, out_ch.open_count);
        fail_count++;
      end else begin
        oldest_verdict = pending_verdicts.pop_front();
        if (out_ch.verdict !== oldest_verdict.verdict) begin
          $display("%0t: verdict mismatch: expected %0d, actual %0d",
                   $time, oldest_verdict.verdict, out_ch.verdict);
          fail_count++;
        end
        if (out_ch.error_code !== oldest_verdict.error_code) begin
          $display("%0t: error_code mismatch: expected %0d, actual %0d",
                   $time, oldest_verdict.error_code, out_ch.error_code);
          fail_count++;
        end
        if (out_ch.open_count !== oldest_verdict.open_count) begin
          $display("%0t: open_count mismatch: expected %0d, actual %0d",
                   $time, oldest_verdict.open_count, out_ch.open_count);
          fail_count++;
        end
      end
    end
    rcv_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_conditional_nesting_tracker_top: FAIL");
      $finish;
    end
  end

  // Unmatched closers, unknown kinds, malformed expressions, taken and
  // untaken branches, skipped nesting and end of file with and without open
  // conditionals.
  task automatic test_directed_cases();
    send_directive(KIND_ENDIF, 1'b0, 1'b1);
    send_directive(KIND_ELSE, 1'b1, 1'b1);
    send_directive(KIND_ELIF, 1'b1, 1'b1);
    send_directive(KIND_UNKNOWN, 1'b1, 1'b0);
    send_directive(KIND_RSVD_6, 1'b0, 1'b1);
    send_directive(KIND_RSVD_7, 1'b1, 1'b1);
    send_directive(KIND_EOF, 1'b0, 1'b0);
    send_directive(KIND_IF, 1'b1, 1'b0);
    // A taken branch: a malformed elif is rejected, later branches are skipped.
    send_directive(KIND_IF, 1'b1, 1'b1);
    send_directive(KIND_ELIF, 1'b1, 1'b0);
    send_directive(KIND_ELIF, 1'b1, 1'b1);
    send_directive(KIND_ELSE, 1'b0, 1'b1);
    send_directive(KIND_ENDIF, 1'b0, 1'b1);
    // An untaken branch with a nested conditional inside the skipped text; the
    // nested open is counted even though its expression is malformed.
    send_directive(KIND_IF, 1'b0, 1'b1);
    send_directive(KIND_IF, 1'b1, 1'b0);
    send_directive(KIND_ELIF, 1'b1, 1'b1);
    send_directive(KIND_ELSE, 1'b0, 1'b1);
    send_directive(KIND_ENDIF, 1'b0, 1'b1);
    send_directive(KIND_ELIF, 1'b1, 1'b1);
    send_directive(KIND_ENDIF, 1'b0, 1'b1);
    // Else after an untaken branch, then end of file with one still open.
    send_directive(KIND_IF, 1'b0, 1'b1);
    send_directive(KIND_ELSE, 1'b1, 1'b0);
    send_directive(KIND_EOF, 1'b1, 1'b1);
  endtask

  // Fills the stack, then tries one more open both malformed and well formed,
  // and closes everything with an end of file that reports the full depth.
  task automatic test_stack_full();
    int unsigned n;
    for (n = 0; n < DEPTH_LIMIT; n++) begin
      send_directive(KIND_IF, 1'b1, 1'b1);
    end
    send_directive(KIND_IF, 1'b1, 1'b0);
    send_directive(KIND_IF, 1'b0, 1'b1);
    send_directive(KIND_EOF, 1'b0, 1'b1);
  endtask

  // One phase of random traffic. Most directives follow a loosely well-formed
  // nesting shape that aims at a chosen depth, now and then a deep one that
  // can overflow the stack; the rest is noise of any kind. Once in a while the
  // sender waits for all results before going on.
  task automatic run_random_phase(input int unsigned count, input int unsigned s_pct,
                                  input int unsigned r_pct);
    int unsigned n;
    int unsigned roll;
    int unsigned gen_open;
    int unsigned nest_goal;
    logic        v;
    logic        ok;
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    gen_open  = 0;
    nest_goal = $urandom_range(1, 5);
    for (n = 0; n < count; n++) begin
      if (n % 97 == 96) begin
        wait_results_drained();
      end
      roll = $urandom_range(0, 99);
      v    = 1'($urandom_range(0, 1));
      ok   = ($urandom_range(0, 15) != 0);
      if (roll < 6) begin
        send_directive(KIND_W'($urandom_range(0, 7)), v, 1'($urandom_range(0, 1)));
      end else if (roll < 8) begin
        send_directive(KIND_EOF, v, ok);
        gen_open  = 0;
        nest_goal = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 32)
                                                 : $urandom_range(1, 5);
      end else if (gen_open < nest_goal && (gen_open == 0 || roll < 45)) begin
        send_directive(KIND_IF, v, ok);
        gen_open++;
      end else if (roll < 60) begin
        send_directive(KIND_ELIF, v, ok);
      end else if (roll < 72) begin
        send_directive(KIND_ELSE, v, ok);
      end else begin
        send_directive(KIND_ENDIF, v, ok);
        if (gen_open > 0) begin
          gen_open--;
        end
      end
    end
  endtask

  // Random traffic under each idling pattern in turn.
  task automatic test_random_traffic();
    run_random_phase(150, 0, 0);
    run_random_phase(150, 61, 0);
    run_random_phase(150, 0, 61);
    run_random_phase(150, 26, 26);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_stack_full();
    test_random_traffic();
    wait_results_drained();
    // Give a late or duplicated result time to show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_conditional_nesting_tracker_top: PASS");
    end else begin
      $display("tb_conditional_nesting_tracker_top: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/cndtrk_pkg.sv
rtl/cndtrk_in_if.sv
rtl/cndtrk_out_if.sv
rtl/cndtrk_stack_mem.sv
rtl/cndtrk_exec.sv
rtl/conditional_nesting_tracker_top.sv
sim/tb_conditional_nesting_tracker_top.sv
